FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, disabled while reset is asserted (active low)
`define PPU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define PPU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PPU_ASSERT(lbl, clk, rstn, prop, msg)

`define PPU_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: design/ppu_pkg.sv
// ---------------------------------------------------------------------------
// ppu_pkg
// Types, codes and helper functions of the palette pixel unpacker.
// ---------------------------------------------------------------------------
package ppu_pkg;

  localparam int CFG_DW       = 11;
  localparam int ADDRESS_BITS = 20;

  typedef enum logic [2:0] {
    REG_PIXEL_FORMAT = 3'd0,
    REG_ABGR_ORDER   = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_ROW_STRIDE   = 3'd4
  } cfg_reg_t;

  localparam logic [2:0] FMT_1BPP   = 3'd0;
  localparam logic [2:0] FMT_4BPP   = 3'd1;
  localparam logic [2:0] FMT_8BPP   = 3'd2;
  localparam logic [2:0] FMT_RGB24  = 3'd3;
  localparam logic [2:0] FMT_RGBA32 = 3'd4;

  localparam logic [CFG_DW-1:0] DIM_MAX        = 11'd1024;
  localparam logic [CFG_DW-1:0] WIDTH_RST      = 11'd320;
  localparam logic [CFG_DW-1:0] HEIGHT_RST     = 11'd200;
  localparam logic [CFG_DW-1:0] STRIDE_RST     = 11'd320;
  localparam logic [31:0]       OPAQUE_ALPHA   = 32'hff000000;

  // zero or oversize dimension counts as the maximum
  function automatic logic [CFG_DW-1:0] dim_limit(input logic [CFG_DW-1:0] v);
    return ((v == '0) || (v > DIM_MAX)) ? DIM_MAX : v;
  endfunction

  // swap red and blue when ABGR is selected
  function automatic logic [31:0] order_color(input logic [31:0] c, input logic abgr);
    return abgr ? {c[31:24], c[7:0], c[15:8], c[23:16]} : c;
  endfunction

endpackage

FILE: design/ppu_if.sv
// ---------------------------------------------------------------------------
// ppu_if
// Valid/ready channels of the palette pixel unpacker: byte/palette input
// and pixel output.
// ---------------------------------------------------------------------------
interface ppu_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  data_byte;
  logic [7:0]  palette_index;
  logic [31:0] palette_color;

  modport source (output valid, mode, data_byte, palette_index, palette_color,
                  input ready);
  modport sink   (input valid, mode, data_byte, palette_index, palette_color,
                  output ready);
endinterface

interface ppu_out_if
  import ppu_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [31:0]             pixel_value;
  logic [ADDRESS_BITS-1:0] pixel_address;
  logic                    last_of_run;
  logic                    end_of_image;

  modport source (output valid, pixel_value, pixel_address, last_of_run, end_of_image,
                  input ready);
  modport sink   (input valid, pixel_value, pixel_address, last_of_run, end_of_image,
                  output ready);
endinterface

FILE: design/palette_pixel_unpacker.sv
// ---------------------------------------------------------------------------
// palette_pixel_unpacker
// Decodes a raw image byte stream (1/4/8 bpp indexed, 24/32 bpp direct)
// into 32-bit pixels with frame-buffer addresses.
// ---------------------------------------------------------------------------
// Pixels leave at one per cycle unless the output stalls, set by the single
// read port of the palette memory: a 1bpp byte occupies the unpack stage for
// eight palette reads, a 4bpp byte for two and an 8bpp byte for one.
// Direct-color bytes and palette writes are taken one per cycle while the
// unpack stage is empty or finishing a byte. A palette write waits until
// the pending pixels of the previous byte have read the palette. Write
// configuration only while the block is idle; the block does not check this.
`include "assert_macros.svh"

module palette_pixel_unpacker
  import ppu_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  ppu_in_if.sink            in_ch,
  ppu_out_if.source         out_ch
);

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  // configuration
  logic [2:0]        fmt_r;
  logic              abgr_r;
  logic [CFG_DW-1:0] width_r, height_r, stride_r;

  // multi-byte pixel assembly
  logic [1:0]  phase_r, phase_nxt;
  logic [23:0] partial_r, partial_nxt;

  // unpack stage
  logic        b_vld_r;
  logic [3:0]  b_rem_r;
  logic [7:0]  b_shift_r;
  logic [2:0]  b_fmt_r;
  logic        b_direct_r;
  logic [31:0] b_dval_r;

  // palette read stage
  logic        c_vld_r, c_last_r, c_direct_r, c_zero_r;
  logic [31:0] c_dval_r;
  logic [31:0] rd_data_r;
  logic [31:0] pal_mem [PALETTE_DEPTH];

  // position
  logic [9:0]              col_r, row_r;
  logic [ADDRESS_BITS-1:0] base_r;

  // output register
  logic                    o_vld_r, o_last_r, o_eoi_r;
  logic [31:0]             o_pix_r;
  logic [ADDRESS_BITS-1:0] o_addr_r;

  logic in_acc, data_acc, pal_wr;
  logic b_issue, b_fin, c_free, out_take, c_xfer;
  logic load_b, load_direct;
  logic [3:0]  load_rem;
  logic [31:0] load_dval;
  logic [7:0]  rd_idx;
  logic        rd_in_range;
  logic [31:0] c_raw;
  logic [CFG_DW-1:0] width_lim, height_lim;
  logic col_end, row_end, eoi;
  logic [ADDRESS_BITS-1:0] addr_cur;

  assign out_take = !o_vld_r || out_ch.ready;
  assign c_free   = !c_vld_r || out_take;
  assign c_xfer   = c_vld_r && out_take;
  assign b_issue  = b_vld_r && c_free;
  assign b_fin    = b_issue && (b_rem_r == 4'd1);

  assign in_ch.ready = !b_vld_r || b_fin;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign data_acc    = in_acc && !in_ch.mode;
  assign pal_wr      = in_acc && in_ch.mode &&
                       ({1'b0, in_ch.palette_index} < 9'(PALETTE_DEPTH));

  // byte decode at accept
  always_comb begin
    load_b      = 1'b0;
    load_direct = 1'b0;
    load_rem    = 4'd1;
    load_dval   = '0;
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    case (fmt_r)
      FMT_1BPP: begin
        load_b   = 1'b1;
        load_rem = 4'd8;
      end
      FMT_4BPP: begin
        load_b   = 1'b1;
        load_rem = 4'd2;
      end
      FMT_8BPP: begin
        load_b = 1'b1;
      end
      FMT_RGB24: begin
        if (phase_r >= 2'd2) begin
          load_b      = 1'b1;
          load_direct = 1'b1;
          load_dval   = OPAQUE_ALPHA | {8'h00, partial_r[23:8], in_ch.data_byte};
          phase_nxt   = 2'd0;
          partial_nxt = '0;
        end else begin
          partial_nxt = partial_r | ({in_ch.data_byte, 16'h0000} >> {phase_r, 3'b000});
          phase_nxt   = phase_r + 2'd1;
        end
      end
      FMT_RGBA32: begin
        if (phase_r == 2'd3) begin
          load_b      = 1'b1;
          load_direct = 1'b1;
          load_dval   = {in_ch.data_byte, partial_r};
          phase_nxt   = 2'd0;
          partial_nxt = '0;
        end else begin
          partial_nxt = partial_r | ({in_ch.data_byte, 16'h0000} >> {phase_r, 3'b000});
          phase_nxt   = phase_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // palette index of the pixel at the head of the unpack stage
  always_comb begin
    case (b_fmt_r)
      FMT_1BPP: rd_idx = {7'b0, b_shift_r[7]};
      FMT_4BPP: rd_idx = {4'b0, b_shift_r[7:4]};
      default:  rd_idx = b_shift_r;
    endcase
  end
  assign rd_in_range = ({1'b0, rd_idx} < 9'(PALETTE_DEPTH));

  // config, assembly and unpack stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_8BPP;
      abgr_r    <= 1'b0;
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      stride_r  <= STRIDE_RST;
      phase_r   <= '0;
      partial_r <= '0;
      b_vld_r   <= 1'b0;
      b_rem_r   <= '0;
    end else begin
      if (data_acc) begin
        phase_r   <= phase_nxt;
        partial_r <= partial_nxt;
      end
      if (data_acc && load_b) begin
        b_vld_r <= 1'b1;
        b_rem_r <= load_rem;
      end else if (b_issue) begin
        b_rem_r <= b_rem_r - 4'd1;
        if (b_fin) begin
          b_vld_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PIXEL_FORMAT: begin
            fmt_r     <= cfg_data[2:0];
            phase_r   <= '0;
            partial_r <= '0;
          end
          REG_ABGR_ORDER:   abgr_r   <= cfg_data[0];
          REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          REG_IMAGE_HEIGHT: height_r <= cfg_data;
          REG_ROW_STRIDE:   stride_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc && load_b) begin
      b_shift_r  <= in_ch.data_byte;
      b_fmt_r    <= fmt_r;
      b_direct_r <= load_direct;
      b_dval_r   <= load_dval;
    end else if (b_issue) begin
      b_shift_r <= (b_fmt_r == FMT_1BPP) ? {b_shift_r[6:0], 1'b0} : {b_shift_r[3:0], 4'h0};
    end
  end

  // palette memory, read-first
  always_ff @(posedge clk) begin
    if (pal_wr) begin
      pal_mem[in_ch.palette_index[PAL_AW-1:0]] <= in_ch.palette_color;
    end
    if (b_issue) begin
      rd_data_r <= pal_mem[rd_idx[PAL_AW-1:0]];
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (b_issue) begin
      c_vld_r <= 1'b1;
    end else if (c_xfer) begin
      c_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_issue) begin
      c_last_r   <= (b_rem_r == 4'd1);
      c_direct_r <= b_direct_r;
      c_zero_r   <= !rd_in_range;
      c_dval_r   <= b_dval_r;
    end
  end

  // position and flags
  assign width_lim  = dim_limit(width_r);
  assign height_lim = dim_limit(height_r);
  assign col_end    = ({1'b0, col_r} + 11'd1) >= width_lim;
  assign row_end    = ({1'b0, row_r} + 11'd1) >= height_lim;
  assign eoi        = col_end && row_end;
  assign addr_cur   = base_r + ADDRESS_BITS'(col_r);
  assign c_raw      = c_direct_r ? c_dval_r : (c_zero_r ? '0 : rd_data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      base_r  <= '0;
      o_vld_r <= 1'b0;
    end else begin
      if (c_xfer) begin
        o_vld_r <= 1'b1;
        if (col_end) begin
          col_r <= '0;
          if (row_end) begin
            row_r  <= '0;
            base_r <= '0;
          end else begin
            row_r  <= row_r + 10'd1;
            base_r <= base_r + ADDRESS_BITS'(stride_r);
          end
        end else begin
          col_r <= col_r + 10'd1;
        end
      end else if (out_ch.ready) begin
        o_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_xfer) begin
      o_pix_r  <= order_color(c_raw, abgr_r);
      o_addr_r <= addr_cur;
      o_last_r <= c_last_r;
      o_eoi_r  <= eoi;
    end
  end

  assign out_ch.valid         = o_vld_r;
  assign out_ch.pixel_value   = o_pix_r;
  assign out_ch.pixel_address = o_addr_r;
  assign out_ch.last_of_run   = o_last_r;
  assign out_ch.end_of_image  = o_eoi_r;

  `PPU_ASSERT(a_rem_range, clk, rst_n, (b_vld_r |-> (b_rem_r != 4'd0) && (b_rem_r <= 4'd8)), "unpack count out of range")
  `PPU_ASSERT(a_pal_order, clk, rst_n, ((in_acc && in_ch.mode) |-> (!b_vld_r || (b_rem_r == 4'd1))), "palette write passed pending reads")
  `PPU_ASSERT(a_c_hold, clk, rst_n, ((c_vld_r && !out_take) |=> (c_vld_r && $stable(rd_data_r))), "read stage lost a pixel")
  `PPU_ASSERT(a_eoi_wrap, clk, rst_n, ((c_xfer && eoi) |=> ((row_r == 10'd0) && (col_r == 10'd0) && (base_r == '0))), "image end did not restart counting")
  `PPU_ASSERT_ALWAYS(a_rst_idle, clk, ((!rst_n) |=> (!o_vld_r && !c_vld_r && !b_vld_r)), "pipeline not empty after reset")

endmodule

FILE: sim/ppu_pixel_monitor.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ppu_pixel_monitor
// Watches the configuration port and both channels of the pixel unpacker.
// Every data byte is decoded into the pixels it should produce. Each output
// beat is then checked field by field against the oldest expected pixel.
// ---------------------------------------------------------------------------
module ppu_pixel_monitor
  import ppu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  ppu_in_if                 in_ch,
  ppu_out_if                out_ch,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic [31:0] value;
    logic [19:0] address;
    logic        last;
    logic        eoi;
  } pixel_t;

  pixel_t      expected_pixels[$];
  logic [31:0] palette_mem [256];
  logic [1:0]  byte_cnt;
  logic [23:0] color_acc;
  logic [9:0]  col;
  logic [9:0]  row;
  logic [19:0] row_base;
  logic [2:0]  fmt;
  logic        abgr;
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [10:0] stride_reg;

  function automatic logic [10:0] eff_dim(input logic [10:0] v);
    if (v == 11'd0 || v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function automatic logic [31:0] out_order(input logic [31:0] argb);
    if (!abgr) return argb;
    return {argb[31:24], argb[7:0], argb[15:8], argb[23:16]};
  endfunction

  // address from the current position, then step column / row / image
  task automatic push_pixel(input logic [31:0] value, input logic last);
    pixel_t px;
    px.value   = value;
    px.address = row_base + 20'(col);
    px.last    = last;
    px.eoi     = 1'b0;
    if (11'(col) + 11'd1 >= eff_dim(width_reg)) begin
      col = '0;
      if (11'(row) + 11'd1 >= eff_dim(height_reg)) begin
        row      = '0;
        row_base = '0;
        px.eoi   = 1'b1;
      end else begin
        row      = row + 10'd1;
        row_base = row_base + 20'(stride_reg);
      end
    end else begin
      col = col + 10'd1;
    end
    expected_pixels.push_back(px);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int s;
    case (fmt)
      FMT_1BPP: begin
        for (s = 7; s >= 0; s--)
          push_pixel(out_order(b[s] ? palette_mem[1] : palette_mem[0]), s == 0);
      end
      FMT_4BPP: begin
        push_pixel(out_order(palette_mem[b[7:4]]), 1'b0);
        push_pixel(out_order(palette_mem[b[3:0]]), 1'b1);
      end
      FMT_8BPP: push_pixel(out_order(palette_mem[b]), 1'b1);
      FMT_RGB24: begin
        if (byte_cnt >= 2'd2) begin
          push_pixel(out_order(OPAQUE_ALPHA | {8'h00, color_acc[23:8], b}), 1'b1);
          byte_cnt  = '0;
          color_acc = '0;
        end else begin
          color_acc = color_acc | (24'(b) << (16 - 8 * byte_cnt));
          byte_cnt  = byte_cnt + 2'd1;
        end
      end
      FMT_RGBA32: begin
        if (byte_cnt >= 2'd3) begin
          push_pixel(out_order({b, color_acc}), 1'b1);
          byte_cnt  = '0;
          color_acc = '0;
        end else begin
          color_acc = color_acc | (24'(b) << (16 - 8 * byte_cnt));
          byte_cnt  = byte_cnt + 2'd1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : monitor_proc
    pixel_t px;
    if (!rst_n) begin
      byte_cnt   = '0;
      color_acc  = '0;
      col        = '0;
      row        = '0;
      row_base   = '0;
      fmt        = FMT_8BPP;
      abgr       = 1'b0;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      stride_reg = STRIDE_RST;
      fail_count = 0;
      expected_pixels.delete();
    end else begin
      // output beat first so a same-edge input can not mask a stray pixel
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display("%0t: pixel beat with nothing expected: value %h address %h",
                   $time, out_ch.pixel_value, out_ch.pixel_address);
        end else begin
          px = expected_pixels.pop_front();
          compare_field("pixel_value", px.value, out_ch.pixel_value);
          compare_field("pixel_address", 32'(px.address), 32'(out_ch.pixel_address));
          compare_field("last_of_run", 32'(px.last), 32'(out_ch.last_of_run));
          compare_field("end_of_image", 32'(px.eoi), 32'(out_ch.end_of_image));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PIXEL_FORMAT: begin
            fmt       = cfg_data[2:0];
            byte_cnt  = '0;
            color_acc = '0;
          end
          REG_ABGR_ORDER:   abgr       = cfg_data[0];
          REG_IMAGE_WIDTH:  width_reg  = cfg_data;
          REG_IMAGE_HEIGHT: height_reg = cfg_data;
          REG_ROW_STRIDE:   stride_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode) palette_mem[in_ch.palette_index] = in_ch.palette_color;
        else decode_byte(in_ch.data_byte);
      end
    end
    pending_count = expected_pixels.size();
  end

endmodule

FILE: sim/palette_pixel_unpacker_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// palette_pixel_unpacker_test
// Drives image bytes and palette loads into the unpacker under a range of
// formats, orders and image geometries, with random gaps and stalls on both
// channels; the pixel monitor predicts and checks every output beat.
// ---------------------------------------------------------------------------
module palette_pixel_unpacker_test;
  import ppu_pkg::*;

  localparam int         IDLE_LIMIT   = 4000;
  localparam int         RANDOM_ITEMS = 110;
  localparam int         HOLD_CYCLES  = 300;
  localparam logic       MODE_PIXEL   = 1'b0;
  localparam logic       MODE_PALETTE = 1'b1;
  localparam logic [2:0] FMT_UNUSED   = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  int                fail_count;
  int                pending_count;
  int                idle_cycles = 0;
  int                items_sent;
  logic [2:0]        cur_fmt;
  bit                pal_loaded [256];
  bit                steady_send;
  bit                hold_req;

  ppu_in_if  in_if();
  ppu_out_if out_if();

  palette_pixel_unpacker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  ppu_pixel_monitor u_pixel_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // pixel sink: short and long stalls, stall-free runs, one long hold
  initial begin : sink_proc
    int stall_left;
    int run_left;
    int r;
    stall_left = 0;
    run_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
        run_left = 1;
      end else if (stall_left == 0 && run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          run_left = $urandom_range(20, 60);
        end else begin
          stall_left = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
          run_left = $urandom_range(1, 6);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        run_left--;
        out_if.ready <= 1'b1;
      end
    end
  end

  // entered and left at a falling edge; valid stays up for the next beat
  task automatic put_item(input logic mode, input logic [7:0] b, input logic [7:0] idx,
                          input logic [31:0] color);
    int gap;
    int r;
    gap = 0;
    if (!steady_send) begin
      r = $urandom_range(0, 99);
      if (r < 10) gap = $urandom_range(10, 40);
      else if (r < 40) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.mode          <= mode;
    in_if.data_byte     <= b;
    in_if.palette_index <= idx;
    in_if.palette_color <= color;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_palette(input logic [7:0] idx, input logic [31:0] color);
    put_item(MODE_PALETTE, 8'($urandom), idx, color);
    pal_loaded[idx] = 1'b1;
  endtask

  task automatic load_entry(input logic [7:0] idx);
    if (!pal_loaded[idx]) write_palette(idx, $urandom);
  endtask

  // make sure every entry the byte will read has been loaded first
  task automatic feed_byte(input logic [7:0] b);
    case (cur_fmt)
      FMT_1BPP: begin
        load_entry(8'd0);
        load_entry(8'd1);
      end
      FMT_4BPP: begin
        load_entry({4'h0, b[7:4]});
        load_entry({4'h0, b[3:0]});
      end
      FMT_8BPP: load_entry(b);
      default: ;
    endcase
    put_item(MODE_PIXEL, b, 8'($urandom), $urandom);
  endtask

  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (r == REG_PIXEL_FORMAT) cur_fmt = v[2:0];
  endtask

  task automatic configure(input logic [2:0] fmt, input logic abgr,
                           input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                           input logic [CFG_DW-1:0] stride);
    quiesce();
    write_reg(REG_PIXEL_FORMAT, CFG_DW'(fmt));
    write_reg(REG_ABGR_ORDER, CFG_DW'(abgr));
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_ROW_STRIDE, stride);
  endtask

  function automatic logic [CFG_DW-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CFG_DW'($urandom_range(1, 8));
    if (r < 85) return CFG_DW'($urandom_range(9, 1024));
    case ($urandom_range(0, 2))
      0: return '0;
      1: return DIM_MAX;
      default: return '1;
    endcase
  endfunction

  initial begin : stim_proc
    int r;
    int n;
    int phase_no;
    logic [2:0] f;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PIXEL_FORMAT;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_PIXEL;
    in_if.data_byte = '0;
    in_if.palette_index = '0;
    in_if.palette_color = '0;
    cur_fmt = FMT_8BPP;
    steady_send = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry, 8bpp ARGB
    feed_byte(8'h00);
    feed_byte(8'hff);
    // unused format code drops data bytes
    configure(FMT_UNUSED, 1'b1, '0, '1, '0);
    feed_byte(8'ha5);
    // 24bpp in ABGR, then a partial pixel cut off by a format write
    configure(FMT_RGB24, 1'b1, DIM_MAX, DIM_MAX, DIM_MAX);
    feed_byte(8'h12);
    feed_byte(8'h34);
    feed_byte(8'h56);
    feed_byte(8'h9a);
    quiesce();
    write_reg(REG_PIXEL_FORMAT, CFG_DW'(FMT_RGB24));
    feed_byte(8'h11);
    feed_byte(8'h22);
    feed_byte(8'h33);
    // 32bpp with zero / oversize dimensions and zero stride
    configure(FMT_RGBA32, 1'b0, '0, '1, '0);
    feed_byte(8'h01);
    feed_byte(8'h02);
    feed_byte(8'h03);
    feed_byte(8'hfe);
    // 1bpp with a width that bytes straddle, rows and image end inside a byte
    configure(FMT_1BPP, 1'b1, CFG_DW'(3), CFG_DW'(2), '1);
    feed_byte(8'h80);
    feed_byte(8'h7f);
    // 4bpp, 1x1 image: width and height drop below the running counts
    configure(FMT_4BPP, 1'b0, CFG_DW'(1), CFG_DW'(1), CFG_DW'(1));
    feed_byte(8'hf0);
    feed_byte(8'h0f);

    phase_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (phase_no == 0) f = FMT_1BPP;
      else if (r < 8) f = 3'($urandom_range(FMT_RGBA32 + 1, FMT_UNUSED));
      else f = 3'($urandom_range(FMT_1BPP, FMT_RGBA32));
      configure(f, 1'($urandom), pick_dim(), pick_dim(), CFG_DW'($urandom));
      steady_send = (phase_no == 0) || ($urandom_range(0, 3) == 0);
      // first phase: sink holds off while bytes keep coming
      if (phase_no == 0) hold_req = 1'b1;
      n = (phase_no == 0) ? 24 : $urandom_range(8, 24);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          write_palette(8'($urandom), $urandom);
        end else begin
          feed_byte(8'($urandom));
        end
      end
      steady_send = 1'b0;
      phase_no++;
    end

    quiesce();
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
